// ===== sv/hps_pkg.sv =====
// Package for the haptic pattern sequencer: opcodes, phase codes, register map,
// result types and the per-pattern step function.
// Depends on nothing; the sequencer and the testbench files import it.
package hps_pkg;

  // Pattern drive constants.
  localparam logic [7:0] DRIVE_LEVEL      = 8'd255;
  localparam logic [1:0] PULSES_PER_BURST = 2'd3;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_CONFIRM = 2'd0;
  localparam logic [1:0] OP_WAIT    = 2'd1;
  localparam logic [1:0] OP_DIR     = 2'd2;
  localparam logic [1:0] OP_RESET   = 2'd3;

  // Motor codes.
  localparam logic [1:0] MOTOR_LEFT  = 2'd0;
  localparam logic [1:0] MOTOR_RIGHT = 2'd1;
  localparam logic [1:0] MOTOR_BOTH  = 2'd2;

  // Commands.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STOP  = 1'b1;

  // Pattern phases; the directional pattern never enters the rest phase.
  localparam logic [1:0] PH_START = 2'd0;
  localparam logic [1:0] PH_ON    = 2'd1;
  localparam logic [1:0] PH_GAP   = 2'd2;
  localparam logic [1:0] PH_REST  = 2'd3;

  // Register map.
  localparam int NUM_REGS  = 8;
  localparam int REG_IDX_W = $clog2(NUM_REGS);
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM_ON   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM_GAP  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CONFIRM_REST = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_ON      = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_GAP     = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_WAIT_REST    = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_DIR_ON       = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_DIR_GAP      = 3'd7;

  localparam logic [15:0] REG_RESET [NUM_REGS] = '{
    16'd600, 16'd400, 16'd1500, 16'd150, 16'd500, 16'd3000, 16'd200, 16'd700
  };

  // One result transaction.
  typedef struct packed {
    logic       command;
    logic [1:0] motor_id;
    logic [7:0] drive_level;
    logic       last;
  } result_t;

  // State of one burst pattern.
  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] mark;
    logic [1:0]  count;
  } burst_t;

  // Outcome of one burst step.
  typedef struct packed {
    burst_t  nxt;
    logic    emit;
    result_t res;
  } burst_step_t;

  // Modular elapsed-time test against a 16-bit duration.
  function automatic logic elapsed(input logic [31:0] now, input logic [31:0] mark,
                                   input logic [15:0] dur);
    logic [31:0] diff;
    diff = now - mark;
    return diff >= {16'd0, dur};
  endfunction

  // Build a start or stop command for a motor.
  function automatic result_t make_cmd(input logic stop, input logic [1:0] motor);
    result_t r;
    r.command     = stop;
    r.motor_id    = motor;
    r.drive_level = stop ? 8'd0 : DRIVE_LEVEL;
    r.last        = 1'b0;
    return r;
  endfunction

  // One poll of a burst pattern.
  function automatic burst_step_t burst_step(input burst_t b, input logic [15:0] on_ms,
                                             input logic [15:0] gap_ms,
                                             input logic [15:0] rest_ms,
                                             input logic [1:0] motor,
                                             input logic [31:0] now);
    burst_step_t s;
    logic [1:0]  cnt;
    s.nxt  = b;
    s.emit = 1'b0;
    s.res  = make_cmd(CMD_STOP, motor);
    cnt    = b.count + 2'd1;
    case (b.phase)
      PH_START: begin
        s.emit      = 1'b1;
        s.res       = make_cmd(CMD_START, motor);
        s.nxt.mark  = now;
        s.nxt.phase = PH_ON;
      end
      PH_ON: begin
        if (elapsed(now, b.mark, on_ms)) begin
          s.emit      = 1'b1;
          s.nxt.mark  = now;
          s.nxt.count = cnt;
          s.nxt.phase = (cnt < PULSES_PER_BURST) ? PH_GAP : PH_REST;
        end
      end
      PH_GAP: begin
        if (elapsed(now, b.mark, gap_ms)) s.nxt.phase = PH_START;
      end
      default: begin
        if (elapsed(now, b.mark, rest_ms)) begin
          s.nxt.phase = PH_START;
          s.nxt.count = 2'd0;
        end
      end
    endcase
    return s;
  endfunction

endpackage

// ===== sv/hps_if.sv =====
// Valid/ready channel interfaces for the haptic pattern sequencer:
// one for poll transactions, one for motor command transactions.
// Depends on nothing.
interface hps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [1:0]  motor_select;
  logic [31:0] now_ms;

  modport source (output valid, opcode, motor_select, now_ms, input ready);
  modport sink (input valid, opcode, motor_select, now_ms, output ready);
endinterface

interface hps_out_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [1:0] motor_id;
  logic [7:0] drive_level;
  logic       last;

  modport source (output valid, command, motor_id, drive_level, last, input ready);
  modport sink (input valid, command, motor_id, drive_level, last, output ready);
endinterface

// ===== sv/haptic_pattern_sequencer.sv =====
// Top level of the haptic pattern sequencer: register file, pattern state and
// a four-entry command queue. Depends on hps_pkg and on hps_in_if/hps_out_if.
//
//   channel    direction  transaction
//   in_ch_i    sink       one poll: opcode, motor_select, now_ms
//   out_ch_o   source     one motor command: command, motor_id, drive_level, last
//   APB        slave      write/read of the eight 16-bit duration registers
//
// A poll is accepted in any cycle in which the command queue has room for two
// commands; its pattern state is updated at that edge and its zero, one or two
// commands enter the queue. With the queue empty, the first of them is visible
// on out_ch_o in the next cycle.
// Sustained rate is one poll per cycle while the queue has room; a directional
// motor switch queues two commands, which a ready sink drains at one per cycle.
// Reset clears all pattern state, the queue and restores register defaults.
// A stalled sink fills the queue and then holds in_ch_i.ready low.
module haptic_pattern_sequencer
  import hps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  hps_in_if.sink             in_ch_i,
  hps_out_if.source          out_ch_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // Configuration registers.
  logic [15:0] regs_q [NUM_REGS];
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];
  assign pready  = 1'b1;
  assign prdata  = {16'd0, regs_q[reg_idx]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= REG_RESET[i];
    end else if (psel && penable && pwrite && pready) begin
      regs_q[reg_idx] <= pwdata[15:0];
    end
  end

  // Pattern state.
  burst_t      conf_q, conf_d;
  burst_t      wait_q, wait_d;
  logic [1:0]  dir_phase_q, dir_phase_d;
  logic [31:0] dir_mark_q, dir_mark_d;
  logic [1:0]  dir_prev_q, dir_prev_d;
  logic        dir_active_q, dir_active_d;

  // Command queue.
  result_t     fifo_q [4];
  logic [1:0]  rd_ptr_q, wr_ptr_q;
  logic [2:0]  cnt_q;

  logic        in_acc, out_acc;
  logic [1:0]  motor;
  result_t     res0, res1;
  logic [1:0]  push_n;
  burst_step_t conf_s, wait_s;
  logic        dir_switch, dir_emit;
  logic [1:0]  dir_ph_eff;
  result_t     dir_res;

  assign in_ch_i.ready = (cnt_q <= 3'd2);
  assign in_acc        = in_ch_i.valid && in_ch_i.ready;
  assign out_ch_o.valid = (cnt_q != 3'd0);
  assign out_acc       = out_ch_o.valid && out_ch_o.ready;

  // Motor code three addresses both motors.
  assign motor = (in_ch_i.motor_select == 2'd3) ? MOTOR_BOTH : in_ch_i.motor_select;

  assign conf_s = burst_step(conf_q, regs_q[REG_CONFIRM_ON], regs_q[REG_CONFIRM_GAP],
                             regs_q[REG_CONFIRM_REST], motor, in_ch_i.now_ms);
  assign wait_s = burst_step(wait_q, regs_q[REG_WAIT_ON], regs_q[REG_WAIT_GAP],
                             regs_q[REG_WAIT_REST], motor, in_ch_i.now_ms);

  // Directional pattern: a motor change stops the old motor and restarts.
  assign dir_switch = dir_active_q && (motor != dir_prev_q);
  assign dir_ph_eff = dir_switch ? PH_START : dir_phase_q;

  always_comb begin
    dir_phase_d  = dir_phase_q;
    dir_mark_d   = dir_mark_q;
    dir_active_d = dir_active_q;
    dir_emit     = 1'b0;
    dir_res      = make_cmd(CMD_STOP, motor);
    case (dir_ph_eff)
      PH_START: begin
        dir_emit     = 1'b1;
        dir_res      = make_cmd(CMD_START, motor);
        dir_mark_d   = in_ch_i.now_ms;
        dir_phase_d  = PH_ON;
        dir_active_d = 1'b1;
      end
      PH_ON: begin
        if (elapsed(in_ch_i.now_ms, dir_mark_q, regs_q[REG_DIR_ON])) begin
          dir_emit    = 1'b1;
          dir_mark_d  = in_ch_i.now_ms;
          dir_phase_d = PH_GAP;
        end
      end
      PH_GAP: begin
        if (elapsed(in_ch_i.now_ms, dir_mark_q, regs_q[REG_DIR_GAP])) dir_phase_d = PH_START;
      end
      default: begin
        dir_phase_d = PH_START;
      end
    endcase
  end

  // Select the state update and the commands of the accepted poll.
  always_comb begin
    conf_d     = conf_q;
    wait_d     = wait_q;
    dir_prev_d = dir_prev_q;
    res0       = make_cmd(CMD_STOP, MOTOR_BOTH);
    res1       = dir_res;
    push_n     = 2'd0;
    case (in_ch_i.opcode)
      OP_CONFIRM: begin
        conf_d = conf_s.nxt;
        res0   = conf_s.res;
        push_n = {1'b0, conf_s.emit};
      end
      OP_WAIT: begin
        wait_d = wait_s.nxt;
        res0   = wait_s.res;
        push_n = {1'b0, wait_s.emit};
      end
      OP_DIR: begin
        dir_prev_d = motor;
        res0       = dir_switch ? make_cmd(CMD_STOP, dir_prev_q) : dir_res;
        push_n     = {1'b0, dir_switch} + {1'b0, dir_emit};
      end
      default: begin
        conf_d = '0;
        wait_d = '0;
        push_n = 2'd1;
      end
    endcase
    if (push_n == 2'd2) res1.last = 1'b1;
    else res0.last = 1'b1;
  end

  // Pattern state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      conf_q       <= '0;
      wait_q       <= '0;
      dir_phase_q  <= PH_START;
      dir_mark_q   <= '0;
      dir_prev_q   <= MOTOR_RIGHT;
      dir_active_q <= 1'b0;
    end else if (in_acc) begin
      conf_q     <= conf_d;
      wait_q     <= wait_d;
      dir_prev_q <= dir_prev_d;
      if (in_ch_i.opcode == OP_DIR) begin
        dir_phase_q  <= dir_phase_d;
        dir_mark_q   <= dir_mark_d;
        dir_active_q <= dir_active_d;
      end else if (in_ch_i.opcode == OP_RESET) begin
        dir_phase_q  <= PH_START;
        dir_mark_q   <= '0;
        dir_active_q <= 1'b0;
      end
    end
  end

  // Command queue storage; each entry loads the first or second new command.
  logic [1:0] push_act;
  assign push_act = in_acc ? push_n : 2'd0;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 4; i++) begin
      if (push_act != 2'd0 && wr_ptr_q == 2'(i)) begin
        fifo_q[i] <= res0;
      end else if (push_act == 2'd2 && (wr_ptr_q + 2'd1) == 2'(i)) begin
        fifo_q[i] <= res1;
      end
    end
  end

  // Command queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + push_act;
      rd_ptr_q <= rd_ptr_q + {1'b0, out_acc};
      cnt_q    <= cnt_q + {1'b0, push_act} - {2'b0, out_acc};
    end
  end

  assign out_ch_o.command     = fifo_q[rd_ptr_q].command;
  assign out_ch_o.motor_id    = fifo_q[rd_ptr_q].motor_id;
  assign out_ch_o.drive_level = fifo_q[rd_ptr_q].drive_level;
  assign out_ch_o.last        = fifo_q[rd_ptr_q].last;

  // The queue never holds more than its four entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= 3'd4)
    else $error("command queue overflow");

  // A reset-all poll returns every pattern to its start phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_ch_i.opcode == OP_RESET |=>
      conf_q.phase == PH_START && wait_q.phase == PH_START && !dir_active_q)
    else $error("reset-all left a pattern running");

  // A reset-all poll into an empty queue shows its stop command next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_ch_i.opcode == OP_RESET && cnt_q == 3'd0 |=>
      out_ch_o.valid && out_ch_o.command == CMD_STOP && out_ch_o.last)
    else $error("reset-all stop command missing");

  // The directional pattern is marked active whenever it has left its start phase.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    dir_phase_q != PH_START |-> dir_active_q)
    else $error("directional pattern running while inactive");

endmodule

// ===== tb/haptic_pattern_sequencer_checker.sv =====
// Scoreboard for the haptic pattern sequencer: follows APB register traffic and poll
// transactions, predicts the motor commands and compares every command transaction.
// Depends on hps_pkg and on the hps_in_if/hps_out_if interfaces.
module haptic_pattern_sequencer_checker
  import hps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  hps_in_if                  poll_i,
  hps_out_if                 cmd_i,
  input  logic               psel_i,
  input  logic               penable_i,
  input  logic               pwrite_i,
  input  logic [PADDR_W-1:0] paddr_i,
  input  logic [31:0]        pwdata_i,
  input  logic [31:0]        prdata_i,
  input  logic               pready_i,
  output int                 mismatch_count_o,
  output int                 pending_o,
  output int                 poll_count_o,
  output int                 cmd_count_o,
  output int                 switch_count_o,
  output int                 reset_all_count_o,
  output int                 reads_checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CONFIRM_BURST = 0;
  localparam int WAIT_BURST    = 1;

  // Shadow copy of the duration registers and of the pattern state.
  logic [15:0] dur_ms      [NUM_REGS];
  logic [1:0]  burst_phase [2];
  logic [31:0] burst_mark  [2];
  logic [1:0]  burst_count [2];
  logic [1:0]  dir_phase;
  logic [31:0] dir_mark;
  logic [1:0]  dir_motor;
  logic        dir_on;

  // Motor commands predicted but not yet seen on the output channel.
  result_t     cmd_queue [$];

  int mismatches = 0;
  int polls      = 0;
  int cmds       = 0;
  int switches   = 0;
  int reset_alls = 0;
  int reads      = 0;

  // Modular 32-bit elapsed-time test.
  function automatic logic time_reached(input logic [31:0] now, input logic [31:0] mark,
                                        input logic [15:0] dur);
    logic [31:0] span;
    span = now - mark;
    return span >= 32'(dur);
  endfunction

  task automatic push_cmd(input logic stop, input logic [1:0] motor);
    result_t c;
    c.command     = stop;
    c.motor_id    = motor;
    c.drive_level = (stop == CMD_STOP) ? 8'd0 : DRIVE_LEVEL;
    c.last        = 1'b0;
    cmd_queue.push_back(c);
  endtask

  task automatic clear_patterns();
    for (int p = 0; p < 2; p++) begin
      burst_phase[p] = PH_START;
      burst_mark[p]  = '0;
      burst_count[p] = '0;
    end
    dir_phase = PH_START;
    dir_mark  = '0;
    dir_on    = 1'b0;
  endtask

  // One poll of a three-pulse burst: start, on time, stop, gap, and a rest after the burst.
  task automatic step_burst(input int p, input logic [15:0] on_ms, input logic [15:0] gap_ms,
                            input logic [15:0] rest_ms, input logic [1:0] motor,
                            input logic [31:0] now);
    case (burst_phase[p])
      PH_START: begin
        push_cmd(CMD_START, motor);
        burst_mark[p]  = now;
        burst_phase[p] = PH_ON;
      end
      PH_ON: begin
        if (time_reached(now, burst_mark[p], on_ms)) begin
          push_cmd(CMD_STOP, motor);
          burst_mark[p]  = now;
          burst_count[p] = burst_count[p] + 2'd1;
          burst_phase[p] = (burst_count[p] < PULSES_PER_BURST) ? PH_GAP : PH_REST;
        end
      end
      PH_GAP: begin
        if (time_reached(now, burst_mark[p], gap_ms)) burst_phase[p] = PH_START;
      end
      default: begin
        if (time_reached(now, burst_mark[p], rest_ms)) begin
          burst_phase[p] = PH_START;
          burst_count[p] = 2'd0;
        end
      end
    endcase
  endtask

  // One poll of the directional pattern; a new target stops the old motor first.
  task automatic step_dir(input logic [1:0] motor, input logic [31:0] now);
    if (dir_on && motor != dir_motor) begin
      push_cmd(CMD_STOP, dir_motor);
      dir_phase = PH_START;
      dir_on    = 1'b0;
      switches++;
    end
    dir_motor = motor;
    case (dir_phase)
      PH_START: begin
        push_cmd(CMD_START, motor);
        dir_mark  = now;
        dir_phase = PH_ON;
        dir_on    = 1'b1;
      end
      PH_ON: begin
        if (time_reached(now, dir_mark, dur_ms[REG_DIR_ON])) begin
          push_cmd(CMD_STOP, motor);
          dir_mark  = now;
          dir_phase = PH_GAP;
        end
      end
      PH_GAP: begin
        if (time_reached(now, dir_mark, dur_ms[REG_DIR_GAP])) dir_phase = PH_START;
      end
      default: begin
        dir_phase = PH_START;
      end
    endcase
  endtask

  // Predict the commands of one accepted poll and flag the final one.
  task automatic predict_poll(input logic [1:0] op, input logic [1:0] sel,
                              input logic [31:0] now);
    logic [1:0] motor;
    int         queued;
    result_t    c;
    queued = cmd_queue.size();
    // A select of three addresses both motors.
    motor = (sel > MOTOR_BOTH) ? MOTOR_BOTH : sel;
    case (op)
      OP_CONFIRM: begin
        step_burst(CONFIRM_BURST, dur_ms[REG_CONFIRM_ON], dur_ms[REG_CONFIRM_GAP],
                   dur_ms[REG_CONFIRM_REST], motor, now);
      end
      OP_WAIT: begin
        step_burst(WAIT_BURST, dur_ms[REG_WAIT_ON], dur_ms[REG_WAIT_GAP],
                   dur_ms[REG_WAIT_REST], motor, now);
      end
      OP_DIR: begin
        step_dir(motor, now);
      end
      default: begin
        clear_patterns();
        push_cmd(CMD_STOP, MOTOR_BOTH);
        reset_alls++;
      end
    endcase
    if (cmd_queue.size() > queued) begin
      c      = cmd_queue.pop_back();
      c.last = 1'b1;
      cmd_queue.push_back(c);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Compare one command transaction with the oldest prediction.
  task automatic check_cmd();
    result_t want;
    cmds++;
    if (cmd_queue.size() == 0) begin
      $error("command transaction with nothing predicted: command %0d motor_id %0d",
             cmd_i.command, cmd_i.motor_id);
      mismatches++;
    end else begin
      want = cmd_queue.pop_front();
      check_field("command", 32'(want.command), 32'(cmd_i.command));
      check_field("motor_id", 32'(want.motor_id), 32'(cmd_i.motor_id));
      check_field("drive_level", 32'(want.drive_level), 32'(cmd_i.drive_level));
      check_field("last", 32'(want.last), 32'(cmd_i.last));
    end
  endtask

  // Output transactions are checked before a poll at the same edge adds to the queue.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NUM_REGS; r++) dur_ms[r] = REG_RESET[r];
      clear_patterns();
      dir_motor = MOTOR_RIGHT;
      cmd_queue.delete();
    end else begin
      if (cmd_i.valid && cmd_i.ready) check_cmd();
      if (poll_i.valid && poll_i.ready) begin
        polls++;
        predict_poll(poll_i.opcode, poll_i.motor_select, poll_i.now_ms);
      end
      if (psel_i && penable_i && pready_i) begin
        if (pwrite_i) begin
          dur_ms[paddr_i[PADDR_W-1:2]] = pwdata_i[15:0];
        end else begin
          reads++;
          check_field("prdata", {16'd0, dur_ms[paddr_i[PADDR_W-1:2]]}, prdata_i);
        end
      end
    end
    mismatch_count_o  <= mismatches;
    pending_o         <= cmd_queue.size();
    poll_count_o      <= polls;
    cmd_count_o       <= cmds;
    switch_count_o    <= switches;
    reset_all_count_o <= reset_alls;
    reads_checked_o   <= reads;
  end

endmodule

// ===== tb/haptic_pattern_sequencer_test.sv =====
// Top of the haptic pattern sequencer testbench: clock, reset, APB register setup and
// poll stimulus with random idling. Depends on hps_pkg, the channel interfaces, the
// sequencer RTL and haptic_pattern_sequencer_checker.
module haptic_pattern_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hps_pkg::*;

  localparam int          ITEMS_PER_SETTING = 190;
  localparam int          DRAIN_CYCLES      = 8;
  localparam int          STALL_CYCLES      = 120;
  localparam int unsigned IDLE_PCT          = 35;
  localparam int          TIMEOUT_NS        = 3_000_000;

  typedef enum {SET_ZERO, SET_MAX, SET_SMALL, SET_MID, SET_FULL, SET_DEFAULT} dur_setting_e;

  logic               clk     = 1'b0;
  logic               rst_n   = 1'b0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [31:0]        pwdata  = '0;
  logic [31:0]        prdata;
  logic               pready;

  hps_in_if  poll_ch ();
  hps_out_if cmd_ch ();

  int unsigned send_idle_pct = IDLE_PCT;
  int unsigned sink_idle_pct = IDLE_PCT;
  logic        pressure_on   = 1'b0;
  logic [31:0] sim_now       = '0;
  logic [31:0] time_scale    = 32'd1;
  logic [1:0]  cur_motor     = MOTOR_LEFT;
  int          settings_applied = 0;

  int mismatch_count;
  int pending;
  int poll_count;
  int cmd_count;
  int switch_count;
  int reset_all_count;
  int reads_checked;

  haptic_pattern_sequencer dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .in_ch_i  (poll_ch),
    .out_ch_o (cmd_ch),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  haptic_pattern_sequencer_checker cmd_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .poll_i            (poll_ch),
    .cmd_i             (cmd_ch),
    .psel_i            (psel),
    .penable_i         (penable),
    .pwrite_i          (pwrite),
    .paddr_i           (paddr),
    .pwdata_i          (pwdata),
    .prdata_i          (prdata),
    .pready_i          (pready),
    .mismatch_count_o  (mismatch_count),
    .pending_o         (pending),
    .poll_count_o      (poll_count),
    .cmd_count_o       (cmd_count),
    .switch_count_o    (switch_count),
    .reset_all_count_o (reset_all_count),
    .reads_checked_o   (reads_checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Command sink: random back-pressure, plus one long hold-off while pressure is on.
  initial begin
    logic stalled;
    stalled      = 1'b0;
    cmd_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on && !stalled) begin
        cmd_ch.ready <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk);
        stalled = 1'b1;
      end else begin
        cmd_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
      end
    end
  end

  task automatic apb_write(input int idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx << 2);
    pwdata  <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Each read is compared against the shadow registers by the checker.
  task automatic read_all_regs();
    for (int r = 0; r < NUM_REGS; r++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= PADDR_W'(r << 2);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Wait until every predicted command has come out and the block has settled.
  task automatic drain();
    poll_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_poll(input logic [1:0] op, input logic [1:0] sel,
                           input logic [31:0] now);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      poll_ch.valid <= 1'b0;
      @(posedge clk);
    end
    poll_ch.valid        <= 1'b1;
    poll_ch.opcode       <= op;
    poll_ch.motor_select <= sel;
    poll_ch.now_ms       <= now;
    @(posedge clk);
    while (!poll_ch.ready) @(posedge clk);
  endtask

  // Mostly forward time at the scale of the current durations, some noise and wraps.
  task automatic advance_time();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) sim_now += $urandom_range(0, time_scale);
    else if (r < 75) sim_now += $urandom_range(0, 2 * time_scale + 2);
    else if (r < 88) sim_now += $urandom_range(0, 3);
    else if (r < 94) sim_now = $urandom;
    else if (r < 98) sim_now = 32'hFFFF_FFFF - $urandom_range(0, time_scale);
  endtask

  task automatic random_poll();
    int unsigned r;
    logic [1:0]  op;
    advance_time();
    r = $urandom_range(0, 99);
    if (r < 33) op = OP_CONFIRM;
    else if (r < 66) op = OP_WAIT;
    else if (r < 99) op = OP_DIR;
    else op = OP_RESET;
    if ($urandom_range(0, 99) < 8) cur_motor = 2'($urandom_range(0, 3));
    send_poll(op, cur_motor, sim_now);
  endtask

  task automatic apply_setting(input dur_setting_e kind);
    logic [15:0] value;
    logic [31:0] widest;
    drain();
    widest = 32'd1;
    for (int r = 0; r < NUM_REGS; r++) begin
      case (kind)
        SET_ZERO:  value = 16'd0;
        SET_MAX:   value = 16'hFFFF;
        SET_SMALL: value = 16'($urandom_range(0, 15));
        SET_MID:   value = 16'($urandom_range(0, 300));
        SET_FULL:  value = 16'($urandom);
        default:   value = REG_RESET[r];
      endcase
      apb_write(r, value);
      if (32'(value) > widest) widest = 32'(value);
    end
    read_all_regs();
    time_scale = widest;
    settings_applied++;
  endtask

  task automatic run_phase(input dur_setting_e kind, input logic stress, input logic calm);
    apply_setting(kind);
    if (calm) begin
      send_idle_pct = 0;
      sink_idle_pct = 0;
    end
    if (stress) begin
      send_idle_pct = 0;
      pressure_on <= 1'b1;
    end
    repeat (ITEMS_PER_SETTING) random_poll();
    pressure_on <= 1'b0;
    send_idle_pct = IDLE_PCT;
    sink_idle_pct = IDLE_PCT;
  endtask

  // Directed polls under the reset durations.
  task automatic run_directed();
    send_poll(OP_RESET, MOTOR_LEFT, 32'h0000_0000);
    // Confirm pulse whose on time spans the wrap of the millisecond counter.
    send_poll(OP_CONFIRM, MOTOR_LEFT, 32'hFFFF_FF00);
    send_poll(OP_CONFIRM, MOTOR_LEFT, 32'h0000_0157);
    send_poll(OP_CONFIRM, MOTOR_LEFT, 32'h0000_0158);
    // A select of three means both motors.
    send_poll(OP_WAIT, 2'b11, 32'hFFFF_FFFF);
    send_poll(OP_WAIT, MOTOR_RIGHT, 32'hFFFF_FFFF);
    // Directional pulse, then motor switches in the on and gap phases.
    send_poll(OP_DIR, MOTOR_RIGHT, 32'd0);
    send_poll(OP_DIR, MOTOR_LEFT, 32'd5);
    send_poll(OP_DIR, MOTOR_LEFT, 32'd205);
    send_poll(OP_DIR, MOTOR_BOTH, 32'd206);
    // Time going backward reads as a huge elapsed time.
    send_poll(OP_DIR, MOTOR_BOTH, 32'd100);
    send_poll(OP_DIR, MOTOR_BOTH, 32'd800);
    send_poll(OP_DIR, MOTOR_BOTH, 32'd800);
    // Reset all keeps the previous directional motor but clears the active flag.
    send_poll(OP_RESET, MOTOR_RIGHT, 32'd900);
    send_poll(OP_DIR, 2'b11, 32'hFFFF_FFFF);
    send_poll(OP_DIR, MOTOR_LEFT, 32'd0);
    send_poll(OP_RESET, MOTOR_LEFT, 32'hFFFF_FFFF);
  endtask

  initial begin
    poll_ch.valid        = 1'b0;
    poll_ch.opcode       = OP_CONFIRM;
    poll_ch.motor_select = MOTOR_LEFT;
    poll_ch.now_ms       = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    read_all_regs();
    run_directed();

    run_phase(SET_SMALL, 1'b0, 1'b0);
    run_phase(SET_ZERO, 1'b0, 1'b0);
    run_phase(SET_MID, 1'b0, 1'b0);
    run_phase(SET_MAX, 1'b0, 1'b0);
    run_phase(SET_FULL, 1'b0, 1'b0);
    run_phase(SET_SMALL, 1'b1, 1'b0);
    run_phase(SET_MID, 1'b0, 1'b1);
    run_phase(SET_DEFAULT, 1'b0, 1'b0);
    drain();

    $display("Run covered %0d polls (%0d reset-all) and %0d motor command transactions",
             poll_count, reset_all_count, cmd_count);
    $display("across %0d register settings, %0d directional switches, %0d register reads.",
             settings_applied, switch_count, reads_checked);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d commands still predicted.", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
